@@ design/phd_pkg.sv @@
// Shared types and constants for the packet header deframer.
// Holds the segment codes and the result record used by the parser and output stage.
// No dependencies.
package phd_pkg;

  localparam int unsigned WordBytes = 4;
  localparam int unsigned PosW      = $clog2(WordBytes);

  // Segment codes: which part of the packet the next byte belongs to.
  localparam logic [2:0] SEG_TYPE    = 3'd0;
  localparam logic [2:0] SEG_SEQ     = 3'd1;
  localparam logic [2:0] SEG_ACK     = 3'd2;
  localparam logic [2:0] SEG_LENGTH  = 3'd3;
  localparam logic [2:0] SEG_PAYLOAD = 3'd4;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] payload_index;
    logic        last_of_packet;
    logic        empty_packet;
    logic [31:0] header_type;
    logic [31:0] sequence_number;
    logic [31:0] ack_number;
    logic [31:0] payload_length;
  } res_t;

  // Handshake between the pipeline stages.
  typedef struct packed {
    logic vld;
    logic [7:0] data;
  } byte_t;

endpackage

@@ design/phd_in_stage.sv @@
// Input register of the packet header deframer.
// Captures one byte transaction per cycle unless the downstream stage stalls; depends on phd_pkg.
module phd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    data_byte_i,
  output logic          in_stall_o,
  input  logic          advance_i,
  output phd_pkg::byte_t byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] data_q;

  // The held byte leaves whenever the downstream stage advances.
  assign in_stall_o = vld_q && !advance_i;
  assign vld_d      = in_stall_o ? vld_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      data_q <= data_byte_i;
    end
  end

  assign byte_o.vld  = vld_q;
  assign byte_o.data = data_q;

endmodule

@@ design/phd_parser.sv @@
// Frame parsing state and next-result logic of the packet header deframer.
// Assembles the four header words and walks the payload; depends on phd_pkg.
module phd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  phd_pkg::byte_t byte_i,
  input  logic           advance_i,
  output logic           res_vld_o,
  output phd_pkg::res_t  res_o
);

  logic                     big_q;
  logic [2:0]               seg_q, seg_d, hdr_seg;
  logic [phd_pkg::PosW-1:0] pos_q, pos_d, lane;
  logic [31:0]              asm_q, asm_d, word;
  logic [31:0]              left_q, left_d;
  logic [31:0]              type_q, type_d, seq_q, seq_d, ack_q, ack_d, len_q, len_d;
  logic                     fire;

  assign fire = byte_i.vld && advance_i;

  always_comb begin
    seg_d     = seg_q;
    pos_d     = pos_q;
    asm_d     = asm_q;
    left_d    = left_q;
    type_d    = type_q;
    seq_d     = seq_q;
    ack_d     = ack_q;
    len_d     = len_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    hdr_seg   = (seg_q > phd_pkg::SEG_LENGTH) ? phd_pkg::SEG_TYPE : seg_q;
    lane      = big_q ? ~pos_q : pos_q;
    word      = ((pos_q == '0) ? 32'd0 : asm_q) | ({24'd0, byte_i.data} << {lane, 3'b000});

    if (fire) begin
      case (seg_q)
        phd_pkg::SEG_PAYLOAD: begin
          res_vld_o                = 1'b1;
          res_o.payload_byte       = byte_i.data;
          res_o.payload_index      = len_q - left_q;
          res_o.last_of_packet     = (left_q <= 32'd1);
          res_o.empty_packet       = 1'b0;
          res_o.header_type        = type_q;
          res_o.sequence_number    = seq_q;
          res_o.ack_number         = ack_q;
          res_o.payload_length     = len_q;
          left_d = (left_q != 32'd0) ? left_q - 32'd1 : left_q;
          if (left_d == 32'd0) begin
            seg_d = phd_pkg::SEG_TYPE;
            pos_d = '0;
            asm_d = '0;
          end
        end
        default: begin
          seg_d = hdr_seg;
          if (pos_q != {phd_pkg::PosW{1'b1}}) begin
            pos_d = pos_q + 1'b1;
            asm_d = word;
          end else begin
            pos_d = '0;
            asm_d = '0;
            case (hdr_seg)
              phd_pkg::SEG_TYPE: begin
                type_d = word;
                seg_d  = phd_pkg::SEG_SEQ;
              end
              phd_pkg::SEG_SEQ: begin
                seq_d = word;
                seg_d = phd_pkg::SEG_ACK;
              end
              phd_pkg::SEG_ACK: begin
                ack_d = word;
                seg_d = phd_pkg::SEG_LENGTH;
              end
              default: begin
                len_d = word;
                if (word == 32'd0) begin
                  seg_d                 = phd_pkg::SEG_TYPE;
                  left_d                = 32'd0;
                  res_vld_o             = 1'b1;
                  res_o.last_of_packet  = 1'b1;
                  res_o.empty_packet    = 1'b1;
                  res_o.header_type     = type_q;
                  res_o.sequence_number = seq_q;
                  res_o.ack_number      = ack_q;
                  res_o.payload_length  = word;
                end else begin
                  seg_d  = phd_pkg::SEG_PAYLOAD;
                  left_d = word;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_q  <= 1'b0;
      seg_q  <= phd_pkg::SEG_TYPE;
      pos_q  <= '0;
      asm_q  <= '0;
      left_q <= '0;
      type_q <= '0;
      seq_q  <= '0;
      ack_q  <= '0;
      len_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        big_q <= cfg_wdata_i;
      end
      seg_q  <= seg_d;
      pos_q  <= pos_d;
      asm_q  <= asm_d;
      left_q <= left_d;
      type_q <= type_d;
      seq_q  <= seq_d;
      ack_q  <= ack_d;
      len_q  <= len_d;
    end
  end

  // An empty packet is always the last result and carries a zero length.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_o && res_o.empty_packet |-> res_o.last_of_packet && res_o.payload_length == 32'd0)
    else $error("empty packet result not marked last");

  // While walking the payload there is always at least one byte left.
  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q == phd_pkg::SEG_PAYLOAD |-> left_q != 32'd0)
    else $error("payload segment with nothing left");

  // No header word is half assembled during the payload.
  a_payload_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q == phd_pkg::SEG_PAYLOAD |-> pos_q == '0)
    else $error("byte position not cleared in payload");

  // The final payload byte returns the parser to the type word.
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && seg_q == phd_pkg::SEG_PAYLOAD && left_q == 32'd1 |=> seg_q == phd_pkg::SEG_TYPE)
    else $error("parser did not return to header after last byte");

endmodule

@@ design/phd_out_stage.sv @@
// Result register of the packet header deframer.
// Holds one result transaction until the consumer takes it; depends on phd_pkg.
module phd_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_vld_i,
  input  phd_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          advance_o,
  output logic          out_valid_o,
  output phd_pkg::res_t res_o
);

  logic          vld_q, vld_d;
  phd_pkg::res_t res_q;

  // The register can load whenever it is empty or its content is taken now.
  assign advance_o = !vld_q || !out_stall_i;
  assign vld_d     = advance_o ? res_vld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

@@ design/packet_header_deframer.sv @@
// Top level of the packet header deframer: byte stream in, payload byte results out.
// Instantiates phd_in_stage, phd_parser and phd_out_stage; depends on phd_pkg.
//
//   Channel  Handshake                 Payload
//   -------  ------------------------  ------------------------------------------
//   in       in_valid_i / in_stall_o   data_byte_i
//   out      out_valid_o / out_stall_i payload_byte_o, payload_index_o, flags,
//                                      four header words
//   config   cfg_we_i                  cfg_wdata_i (big_endian_words)
//
// Each byte passes an input register and a result register. Its result is loaded into
// the result register when the parser advances on it, and the consumer takes it from
// there. One byte is accepted every cycle while the output side does not stall; the
// single-pass parser between the two registers sets that rate.
// Reset clears the parser to expect a type word and selects little-endian header words.
// A stall on the output while the result register is full holds that register and, in
// the same cycle, stalls the input whenever a byte waits in the input register; header
// bytes wait as well, although they give no result.

module packet_header_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic [31:0] payload_index_o,
  output logic        last_of_packet_o,
  output logic        empty_packet_o,
  output logic [31:0] header_type_o,
  output logic [31:0] sequence_number_o,
  output logic [31:0] ack_number_o,
  output logic [31:0] payload_length_o
);

  phd_pkg::byte_t in_byte;
  phd_pkg::res_t  next_res, out_res;
  logic           next_vld;
  logic           advance;

  // Input register: the byte waits here while the parser cannot advance.
  phd_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .data_byte_i (data_byte_i),
    .in_stall_o  (in_stall_o),
    .advance_i   (advance),
    .byte_o      (in_byte)
  );

  // Parser: header word assembly, payload count and the next result.
  phd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_i      (in_byte),
    .advance_i   (advance),
    .res_vld_o   (next_vld),
    .res_o       (next_res)
  );

  // Result register: decouples the consumer's stall from the parser.
  phd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (next_vld),
    .res_i       (next_res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign payload_byte_o    = out_res.payload_byte;
  assign payload_index_o   = out_res.payload_index;
  assign last_of_packet_o  = out_res.last_of_packet;
  assign empty_packet_o    = out_res.empty_packet;
  assign header_type_o     = out_res.header_type;
  assign sequence_number_o = out_res.sequence_number;
  assign ack_number_o      = out_res.ack_number;
  assign payload_length_o  = out_res.payload_length;

endmodule

@@ verif/packet_header_deframer_test.sv @@
// Self-checking testbench for packet_header_deframer: byte stream in, payload results out.
// Depends on phd_pkg for the segment codes and the result record, and on the RTL alone.
// A directed table runs first, then randomized packets, junk and byte order changes.
module packet_header_deframer_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no transaction on either channel before the run is declared hung.
  localparam int unsigned QuietLimit = 2000;
  // Two pipeline registers plus margin, waited out before a byte order write.
  localparam int unsigned SettleCycles = 4;
  // Random bytes sent per idling phase.
  localparam int unsigned PhaseBytes = 170;

  // One row of the directed table. A typed row carries the result read straight off
  // the packet layout; all other rows rely on the predictor.
  typedef struct packed {
    logic [7:0]    data;
    logic          set_order;
    logic          order;
    logic          typed;
    phd_pkg::res_t result;
  } stim_row_t;

  // Heartbeat packet with zero payload: one empty result on its last length byte.
  localparam phd_pkg::res_t EmptyHeartbeat = '{
    payload_byte:    8'h00,
    payload_index:   32'd0,
    last_of_packet:  1'b1,
    empty_packet:    1'b1,
    header_type:     32'h0000_0000,
    sequence_number: 32'hFFFF_FFFF,
    ack_number:      32'h1234_5678,
    payload_length:  32'h0000_0000
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  payload_byte_o;
  logic [31:0] payload_index_o;
  logic        last_of_packet_o;
  logic        empty_packet_o;
  logic [31:0] header_type_o;
  logic [31:0] sequence_number_o;
  logic [31:0] ack_number_o;
  logic [31:0] payload_length_o;

  packet_header_deframer dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state: which header word or payload the next byte belongs to, how many
  // bytes of the current header word are in, and the header words of the packet.
  logic [2:0]  parse_part = phd_pkg::SEG_TYPE;
  logic [1:0]  hdr_pos = 2'd0;
  logic [31:0] hdr_acc = 32'd0;
  logic [31:0] bytes_due = 32'd0;
  logic [31:0] hdr_type = 32'd0;
  logic [31:0] hdr_seq = 32'd0;
  logic [31:0] hdr_ack = 32'd0;
  logic [31:0] hdr_len = 32'd0;
  logic        msb_first = 1'b0;

  phd_pkg::res_t awaited_payload [$];
  int unsigned   mismatch_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   sender_idle_pct = 0;
  int unsigned   stall_pct = 0;

  // Steps the predictor by one accepted byte. A result is produced for every payload
  // byte and for the last length byte of a packet whose length is zero.
  task automatic deframe_byte(input logic [7:0] b, output bit produced,
                              output phd_pkg::res_t r);
    logic [31:0] word;
    produced = 1'b0;
    r = '0;
    if (parse_part == phd_pkg::SEG_PAYLOAD) begin
      r.payload_byte   = b;
      r.payload_index  = hdr_len - bytes_due;
      r.last_of_packet = (bytes_due <= 32'd1);
      produced = 1'b1;
      if (bytes_due != 32'd0) bytes_due--;
      if (bytes_due == 32'd0) begin
        parse_part = phd_pkg::SEG_TYPE;
        hdr_pos = 2'd0;
        hdr_acc = 32'd0;
      end
    end else begin
      if (parse_part > phd_pkg::SEG_LENGTH) parse_part = phd_pkg::SEG_TYPE;
      if (hdr_pos == 2'd0) hdr_acc = 32'd0;
      // Each byte lands where the byte order register points at the moment it arrives,
      // so a change in the middle of a word mixes both placements.
      hdr_acc = hdr_acc | (32'(b) << (msb_first ? 8 * (3 - hdr_pos) : 8 * hdr_pos));
      if (hdr_pos != 2'd3) begin
        hdr_pos++;
      end else begin
        word = hdr_acc;
        hdr_pos = 2'd0;
        hdr_acc = 32'd0;
        case (parse_part)
          phd_pkg::SEG_TYPE: begin
            hdr_type = word;
            parse_part = phd_pkg::SEG_SEQ;
          end
          phd_pkg::SEG_SEQ: begin
            hdr_seq = word;
            parse_part = phd_pkg::SEG_ACK;
          end
          phd_pkg::SEG_ACK: begin
            hdr_ack = word;
            parse_part = phd_pkg::SEG_LENGTH;
          end
          default: begin
            hdr_len = word;
            bytes_due = word;
            if (word == 32'd0) begin
              parse_part = phd_pkg::SEG_TYPE;
              r.last_of_packet = 1'b1;
              r.empty_packet = 1'b1;
              produced = 1'b1;
            end else begin
              parse_part = phd_pkg::SEG_PAYLOAD;
            end
          end
        endcase
      end
    end
    if (produced) begin
      r.header_type     = hdr_type;
      r.sequence_number = hdr_seq;
      r.ack_number      = hdr_ack;
      r.payload_length  = hdr_len;
    end
  endtask

  // Presents one byte at a falling edge after a random idle gap, holds it until the
  // transaction completes, and queues what the block should answer with.
  task automatic send_byte(input logic [7:0] value, input bit typed = 1'b0,
                           input phd_pkg::res_t typed_res = '0);
    bit            produced;
    phd_pkg::res_t predicted;
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    deframe_byte(value, produced, predicted);
    if (typed) awaited_payload.push_back(typed_res);
    else if (produced) awaited_payload.push_back(predicted);
  endtask

  // Random byte for junk and fill. While a length word is being built, only its least
  // significant byte gets a small value, so junk never locks the stream into a huge
  // payload. Payload and other header bytes are left fully random.
  function automatic logic [7:0] junk_byte();
    logic [7:0] raw;
    raw = 8'($urandom);
    if (parse_part != phd_pkg::SEG_LENGTH) return raw;
    if (hdr_pos != (msb_first ? 2'd3 : 2'd0)) return 8'h00;
    return {4'h0, raw[3:0]};
  endfunction

  // Brings the stream back to a packet boundary after junk or a cut-off phase.
  task automatic finish_packet();
    while (parse_part != phd_pkg::SEG_TYPE || hdr_pos != 2'd0) send_byte(junk_byte());
  endtask

  // Sends a well-formed header in the current byte order, then payload_count random
  // payload bytes (fewer than len only for the oversized packet at the end).
  task automatic send_packet(input logic [31:0] kind, input logic [31:0] seq,
                             input logic [31:0] ack, input logic [31:0] len,
                             input int unsigned payload_count);
    logic [31:0] words [4];
    words = '{kind, seq, ack, len};
    for (int w = 0; w < 4; w++) begin
      for (int k = 0; k < 4; k++) begin
        send_byte(msb_first ? words[w][8 * (3 - k) +: 8] : words[w][8 * k +: 8]);
      end
    end
    for (int unsigned n = 0; n < payload_count; n++) send_byte(8'($urandom));
  endtask

  // Holds the sender off until every queued result has come out, then lets the
  // pipeline empty of header bytes, which produce nothing to wait for.
  task automatic settle_output();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (awaited_payload.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Called at a falling edge with the block idle; the write lands on the next rising edge.
  task automatic write_byte_order(input logic msb);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= msb;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    msb_first = msb;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: stalls at random with the current phase's rate, changing at falling edges.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Result checker: every completed output transaction is matched, field by field,
  // against the oldest outstanding prediction.
  always @(posedge clk_i) begin
    phd_pkg::res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_payload.size() == 0) begin
        $error("result arrived with no outstanding prediction: byte 0x%0h index %0d",
               payload_byte_o, payload_index_o);
        mismatch_count++;
      end else begin
        want = awaited_payload.pop_front();
        check_field("payload_byte", want.payload_byte, payload_byte_o);
        check_field("payload_index", want.payload_index, payload_index_o);
        check_field("last_of_packet", want.last_of_packet, last_of_packet_o);
        check_field("empty_packet", want.empty_packet, empty_packet_o);
        check_field("header_type", want.header_type, header_type_o);
        check_field("sequence_number", want.sequence_number, sequence_number_o);
        check_field("ack_number", want.ack_number, ack_number_o);
        check_field("payload_length", want.payload_length, payload_length_o);
      end
    end
  end

  // Watchdog: a long run of cycles without a transaction on either channel means the
  // block has hung or dropped a result.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Directed packets. The first is a heartbeat with all-ones bytes in its sequence
  // word and no payload, in the reset byte order. The second flips to most significant
  // byte first halfway through its type word and carries two payload bytes.
  stim_row_t directed_rows [34] = '{
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0}, '{8'hFF, 1'b0, 1'b0, 1'b0, '0},
    '{8'h78, 1'b0, 1'b0, 1'b0, '0}, '{8'h56, 1'b0, 1'b0, 1'b0, '0},
    '{8'h34, 1'b0, 1'b0, 1'b0, '0}, '{8'h12, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b1, EmptyHeartbeat},
    '{8'hA1, 1'b0, 1'b0, 1'b0, '0}, '{8'hB2, 1'b0, 1'b0, 1'b0, '0},
    '{8'hC3, 1'b1, 1'b1, 1'b0, '0}, '{8'hD4, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0}, '{8'h02, 1'b0, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, 1'b0, '0}
  };

  // Idling phases cycle through: none, sender only, receiver only, both.
  int unsigned idle_plan  [4] = '{0, 46, 0, 25};
  int unsigned stall_plan [4] = '{0, 0, 46, 25};

  initial begin
    int unsigned phase_start;
    int unsigned pick;
    logic [31:0] len;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_order) begin
        settle_output();
        write_byte_order(directed_rows[i].order);
      end
      send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].result);
    end

    // Random phases. Each starts from an idle block with a fresh byte order write, so
    // a phase that ended in the middle of a header word checks a mid-word order change.
    for (int ph = 0; ph < 8; ph++) begin
      settle_output();
      write_byte_order(1'(ph % 2));
      sender_idle_pct = idle_plan[ph % 4];
      stall_pct = stall_plan[ph % 4];
      finish_packet();
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        if ($urandom_range(9) == 0) begin
          // Broken sequence: junk that cuts into the framing, then fill to the boundary.
          repeat ($urandom_range(12, 1)) send_byte(junk_byte());
          finish_packet();
        end else begin
          // Mostly short payloads, a quarter empty and some longer ones; a quarter
          // of the packets are heartbeats.
          pick = $urandom_range(99);
          if (pick < 25) len = 32'd0;
          else if (pick < 80) len = $urandom_range(6, 1);
          else len = $urandom_range(40, 7);
          send_packet(($urandom_range(3) == 0) ? 32'd0 : 32'($urandom), 32'($urandom),
                      32'($urandom), len, len);
        end
        // Now and then the sender waits for the output side to drain completely.
        if ($urandom_range(49) == 0) settle_output();
      end
      if ($urandom_range(1) == 1) repeat ($urandom_range(3, 1)) send_byte(junk_byte());
    end

    // Oversized packet: all-ones type, ack and length words, so the index climbs far from the end
    // of the payload and no byte is ever flagged last.
    settle_output();
    write_byte_order(1'b0);
    sender_idle_pct = 25;
    stall_pct = 25;
    finish_packet();
    send_packet(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24);

    settle_output();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
